### rtl/doubly_linked_list_manager_macros.svh
// Assertion macros for the doubly linked list manager.
// Used by the top level; depends on nothing.
`ifndef DOUBLY_LINKED_LIST_MANAGER_MACROS_SVH
`define DOUBLY_LINKED_LIST_MANAGER_MACROS_SVH

// check in the same cycle
`define DLLM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check in the following cycle
`define DLLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/dllm_pkg.sv
// Shared types for the doubly linked list manager: item structs, codes, state
// and the command/status structs between controller and datapath.
package dllm_pkg;

   typedef enum logic [1:0] {
      OP_INIT     = 2'd0,
      OP_ADD_HEAD = 2'd1,
      OP_ADD_TAIL = 2'd2,
      OP_CUT      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE          = 2'd0,
      STAT_ADD_MEMBER    = 2'd1,
      STAT_CUT_NONMEMBER = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_LINK,
      ST_OWNRD,
      ST_UNLINK
   } state_type;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] list_id;
      logic [7:0] node;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       head_valid;
      logic [7:0] head_node;
      logic       tail_valid;
      logic [7:0] tail_node;
   } rsp_type;

   typedef struct packed {
      logic clear_en;
      logic load;
      logic decide;
      logic link;
      logic own_rd;
      logic unlink;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   member;
      logic   head_empty;
      logic   tail_empty;
      logic   sweep_done;
   } dp_stat_type;

endpackage

### rtl/dllm_ctrl.sv
// Controller of the doubly linked list manager: sequences clearing, lookup and
// link updates. Depends on dllm_pkg.
module dllm_ctrl
   import dllm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_IDLE;
            unique case (stat.op)
               OP_INIT: begin
                  state_in = ST_IDLE;
               end
               OP_ADD_HEAD: begin
                  if (!stat.member && !stat.head_empty) begin
                     state_in = ST_LINK;
                  end
               end
               OP_ADD_TAIL: begin
                  if (!stat.member && !stat.tail_empty) begin
                     state_in = ST_LINK;
                  end
               end
               OP_CUT: begin
                  if (stat.member) begin
                     state_in = ST_OWNRD;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_LINK: begin
            cmd.link = 1'b1;
            state_in = ST_IDLE;
         end
         ST_OWNRD: begin
            cmd.own_rd = 1'b1;
            state_in   = ST_UNLINK;
         end
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

### rtl/dllm_dpath.sv
// Datapath of the doubly linked list manager: link, owner and head/tail
// memories, read registers and the result register. Depends on dllm_pkg.
module dllm_dpath
   import dllm_pkg::*;
#(
   parameter int NUM_NODES = 256,
   parameter int NUM_LISTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_item,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output rsp_type     rsp_item,
   output logic        rsp_strobe
);

   localparam int NW    = $clog2(NUM_NODES);
   localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int KW    = $clog2(NUM_NODES + 1);
   localparam int OW    = $clog2(NUM_LISTS + 1);
   localparam int SWEEP = (NUM_NODES > NUM_LISTS) ? NUM_NODES : NUM_LISTS;
   localparam int CW    = $clog2(SWEEP);

   function automatic logic [NW-1:0] node_index(input logic [7:0] v);
      logic [31:0] r;
      r = 32'(v);
      for (int i = 7; i >= 0; i--) begin
         if (r >= (32'(NUM_NODES) << i)) begin
            r = r - (32'(NUM_NODES) << i);
         end
      end
      return r[NW-1:0];
   endfunction

   function automatic logic [LW-1:0] list_index(input logic [1:0] v);
      logic [31:0] r;
      r = 32'(v);
      for (int i = 1; i >= 0; i--) begin
         if (r >= (32'(NUM_LISTS) << i)) begin
            r = r - (32'(NUM_LISTS) << i);
         end
      end
      return r[LW-1:0];
   endfunction

   function automatic logic [NW-1:0] link_idx(input logic [KW-1:0] link);
      logic [KW-1:0] m;
      m = link - KW'(1);
      return m[NW-1:0];
   endfunction

   function automatic logic [7:0] link_node8(input logic [KW-1:0] link);
      logic [KW-1:0] m;
      logic [31:0]   w;
      m = link - KW'(1);
      w = 32'(m);
      return (link != '0) ? w[7:0] : 8'd0;
   endfunction

   function automatic rsp_type report(input status_type st, input logic [KW-1:0] h,
                                      input logic [KW-1:0] t);
      rsp_type r;
      r.status     = st;
      r.head_valid = (h != '0);
      r.head_node  = link_node8(h);
      r.tail_valid = (t != '0);
      r.tail_node  = link_node8(t);
      return r;
   endfunction

   logic [KW-1:0] next_mem  [NUM_NODES];
   logic [KW-1:0] prev_mem  [NUM_NODES];
   logic [OW-1:0] owner_mem [NUM_NODES];
   logic [KW-1:0] head_mem  [NUM_LISTS];
   logic [KW-1:0] tail_mem  [NUM_LISTS];

   op_type        op_ff;
   logic [LW-1:0] lst_ff;
   logic [NW-1:0] nd_ff;
   logic [OW-1:0] owner_rd_ff;
   logic [KW-1:0] next_rd_ff;
   logic [KW-1:0] prev_rd_ff;
   logic [KW-1:0] head_rd_ff;
   logic [KW-1:0] tail_rd_ff;
   logic [CW-1:0] cnt_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_strobe_ff;
   logic          rsp_strobe_in;

   logic [NW-1:0] nd_in;
   logic [LW-1:0] lst_in;
   logic [KW-1:0] self_link;
   logic [OW-1:0] lst_mark;
   logic [OW-1:0] own_dec;
   logic [LW-1:0] own_idx;
   logic [LW-1:0] ht_raddr;
   logic          member;
   logic          add_head;
   logic          add_tail;
   logic          clear_node;
   logic          clear_list;

   logic          next_we;
   logic [NW-1:0] next_waddr;
   logic [KW-1:0] next_wdata;
   logic          prev_we;
   logic [NW-1:0] prev_waddr;
   logic [KW-1:0] prev_wdata;
   logic          owner_we;
   logic [NW-1:0] owner_waddr;
   logic [OW-1:0] owner_wdata;
   logic          head_we;
   logic [LW-1:0] head_waddr;
   logic [KW-1:0] head_wdata;
   logic          tail_we;
   logic [LW-1:0] tail_waddr;
   logic [KW-1:0] tail_wdata;

   assign nd_in      = node_index(req_item.node);
   assign lst_in     = list_index(req_item.list_id);
   assign self_link  = KW'(nd_ff) + KW'(1);
   assign lst_mark   = OW'(lst_ff) + OW'(1);
   assign own_dec    = owner_rd_ff - OW'(1);
   assign own_idx    = own_dec[LW-1:0];
   assign ht_raddr   = cmd.load ? lst_in : own_idx;
   assign member     = (owner_rd_ff != '0);
   assign add_head   = cmd.decide && (op_ff == OP_ADD_HEAD) && !member;
   assign add_tail   = cmd.decide && (op_ff == OP_ADD_TAIL) && !member;
   assign clear_node = cmd.clear_en && (32'(cnt_ff) < NUM_NODES);
   assign clear_list = cmd.clear_en && (32'(cnt_ff) < NUM_LISTS);

   always_comb begin
      next_we    = 1'b0;
      next_waddr = nd_ff;
      next_wdata = '0;
      if (add_head) begin
         next_we    = 1'b1;
         next_wdata = head_rd_ff;
      end else if (add_tail) begin
         next_we    = 1'b1;
      end else if (cmd.link && (op_ff == OP_ADD_TAIL)) begin
         next_we    = 1'b1;
         next_waddr = link_idx(tail_rd_ff);
         next_wdata = self_link;
      end else if (cmd.unlink && (prev_rd_ff != '0)) begin
         next_we    = 1'b1;
         next_waddr = link_idx(prev_rd_ff);
         next_wdata = next_rd_ff;
      end
   end

   always_comb begin
      prev_we    = 1'b0;
      prev_waddr = nd_ff;
      prev_wdata = '0;
      if (add_head) begin
         prev_we    = 1'b1;
      end else if (add_tail) begin
         prev_we    = 1'b1;
         prev_wdata = tail_rd_ff;
      end else if (cmd.link && (op_ff == OP_ADD_HEAD)) begin
         prev_we    = 1'b1;
         prev_waddr = link_idx(head_rd_ff);
         prev_wdata = self_link;
      end else if (cmd.unlink && (next_rd_ff != '0)) begin
         prev_we    = 1'b1;
         prev_waddr = link_idx(next_rd_ff);
         prev_wdata = prev_rd_ff;
      end
   end

   always_comb begin
      owner_we    = 1'b0;
      owner_waddr = nd_ff;
      owner_wdata = '0;
      if (clear_node) begin
         owner_we    = 1'b1;
         owner_waddr = cnt_ff[NW-1:0];
      end else if (add_head || add_tail) begin
         owner_we    = 1'b1;
         owner_wdata = lst_mark;
      end else if (cmd.unlink) begin
         owner_we    = 1'b1;
      end
   end

   always_comb begin
      head_we    = 1'b0;
      head_waddr = lst_ff;
      head_wdata = '0;
      tail_we    = 1'b0;
      tail_waddr = lst_ff;
      tail_wdata = '0;
      if (clear_list) begin
         head_we    = 1'b1;
         head_waddr = cnt_ff[LW-1:0];
         tail_we    = 1'b1;
         tail_waddr = cnt_ff[LW-1:0];
      end else if (cmd.decide && (op_ff == OP_INIT)) begin
         head_we    = 1'b1;
         tail_we    = 1'b1;
      end else if (add_head) begin
         head_we    = 1'b1;
         head_wdata = self_link;
         tail_we    = (head_rd_ff == '0);
         tail_wdata = self_link;
      end else if (add_tail) begin
         tail_we    = 1'b1;
         tail_wdata = self_link;
         head_we    = (tail_rd_ff == '0);
         head_wdata = self_link;
      end else if (cmd.unlink) begin
         head_we    = (head_rd_ff == self_link);
         head_waddr = own_idx;
         head_wdata = next_rd_ff;
         tail_we    = (tail_rd_ff == self_link);
         tail_waddr = own_idx;
         tail_wdata = prev_rd_ff;
      end
   end

   always_comb begin
      rsp_in        = report(STAT_DONE, '0, '0);
      rsp_strobe_in = cmd.unlink;
      if (cmd.unlink) begin
         rsp_in = report(STAT_DONE,
                         (head_rd_ff == self_link) ? next_rd_ff : head_rd_ff,
                         (tail_rd_ff == self_link) ? prev_rd_ff : tail_rd_ff);
      end else if (cmd.decide) begin
         rsp_strobe_in = 1'b1;
         case (op_ff)
            OP_INIT: begin
               rsp_in = report(STAT_DONE, '0, '0);
            end
            OP_ADD_HEAD: begin
               if (member) begin
                  rsp_in = report(STAT_ADD_MEMBER, head_rd_ff, tail_rd_ff);
               end else begin
                  rsp_in = report(STAT_DONE, self_link,
                                  (head_rd_ff == '0) ? self_link : tail_rd_ff);
               end
            end
            OP_ADD_TAIL: begin
               if (member) begin
                  rsp_in = report(STAT_ADD_MEMBER, head_rd_ff, tail_rd_ff);
               end else begin
                  rsp_in = report(STAT_DONE,
                                  (tail_rd_ff == '0) ? self_link : head_rd_ff, self_link);
               end
            end
            OP_CUT: begin
               rsp_strobe_in = !member;
               rsp_in        = report(STAT_CUT_NONMEMBER, '0, '0);
            end
            default: rsp_strobe_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (cmd.load) begin
         next_rd_ff <= next_mem[nd_in];
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (cmd.load) begin
         prev_rd_ff <= prev_mem[nd_in];
      end
   end

   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[owner_waddr] <= owner_wdata;
      end
      if (cmd.load) begin
         owner_rd_ff <= owner_mem[nd_in];
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (tail_we) begin
         tail_mem[tail_waddr] <= tail_wdata;
      end
      if (cmd.load || cmd.own_rd) begin
         head_rd_ff <= head_mem[ht_raddr];
         tail_rd_ff <= tail_mem[ht_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_item.op);
         lst_ff <= lst_in;
         nd_ff  <= nd_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.clear_en) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign stat.op         = op_ff;
   assign stat.member     = member;
   assign stat.head_empty = (head_rd_ff == '0);
   assign stat.tail_empty = (tail_rd_ff == '0);
   assign stat.sweep_done = (32'(cnt_ff) == (SWEEP - 1));

   assign rsp_item   = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

### rtl/doubly_linked_list_manager.sv
// Doubly linked list manager top level: controller plus link/owner datapath.
// An item is taken when start is high and busy low; its result is registered in the decide
// state, or for a member cut in the unlink state, after a read of the owner list's head
// and tail by the owner mark. A new item waits until the last one is done and busy is low;
// an add to a non-empty list also passes the link state (single write port per link memory).
// After synchronous reset busy stays high while the memories are cleared; no result stalls.
`include "doubly_linked_list_manager_macros.svh"

module doubly_linked_list_manager
   import dllm_pkg::*;
#(
   parameter int NUM_NODES = 256,
   parameter int NUM_LISTS = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [5:0]  cmd_bits;

   dllm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   dllm_dpath #(
      .NUM_NODES (NUM_NODES),
      .NUM_LISTS (NUM_LISTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_item   (rsp_item),
      .rsp_strobe (rsp_strobe)
   );

   assign cmd_bits = cmd;

   `DLLM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")
   `DLLM_ASSERT_SAME(a_cmd_onehot, clock, reset, 1'b1, $onehot0(cmd_bits), "command overlap")
   `DLLM_ASSERT_NEXT(a_ownrd_unlink, clock, reset, cmd.own_rd, cmd.unlink, "unlink missing")
   `DLLM_ASSERT_SAME(a_strobe_after_work, clock, reset, rsp_strobe, $past(busy), "stray result")

endmodule

### dv/testbench.sv
// Self-checking testbench for doubly_linked_list_manager: directed list operations, then
// random add/cut/init traffic under varying start gaps, checked against an in-bench list model.
// Depends on dllm_pkg and the doubly_linked_list_manager RTL.
module testbench;
   import dllm_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   logic [8:0] node_next [256];
   logic [8:0] node_prev [256];
   logic [2:0] node_owner [256];
   logic [8:0] list_first [4];
   logic [8:0] list_last [4];

   rsp_type outcome_q[$];
   int      idle_pct = 0;
   int      fail_count = 0;
   int      checked_count = 0;

   doubly_linked_list_manager dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(string msg);
      if (fail_count < 50) begin
         $display("MISMATCH at result %0d: %s", checked_count, msg);
      end
      fail_count++;
   endtask

   function automatic rsp_type pack_outcome(status_type s, logic [8:0] h, logic [8:0] t);
      rsp_type    r;
      logic [8:0] hm;
      logic [8:0] tm;
      hm = h - 9'd1;
      tm = t - 9'd1;
      r.status     = s;
      r.head_valid = (h != 9'd0);
      r.head_node  = (h != 9'd0) ? hm[7:0] : 8'd0;
      r.tail_valid = (t != 9'd0);
      r.tail_node  = (t != 9'd0) ? tm[7:0] : 8'd0;
      return r;
   endfunction

   function automatic rsp_type list_op_outcome(req_type it);
      op_type     op;
      logic [1:0] lst;
      logic [1:0] own;
      logic [2:0] ownm;
      logic [7:0] nd;
      logic [8:0] self;
      logic [8:0] nx;
      logic [8:0] pv;
      logic [8:0] idx;
      op   = op_type'(it.op);
      lst  = it.list_id;
      nd   = it.node;
      self = {1'b0, nd} + 9'd1;
      case (op)
         OP_INIT: begin
            list_first[lst] = 9'd0;
            list_last[lst]  = 9'd0;
            return pack_outcome(STAT_DONE, 9'd0, 9'd0);
         end
         OP_ADD_HEAD, OP_ADD_TAIL: begin
            if (node_owner[nd] != 3'd0) begin
               return pack_outcome(STAT_ADD_MEMBER, list_first[lst], list_last[lst]);
            end
            if (op == OP_ADD_HEAD) begin
               nx = list_first[lst];
               node_next[nd] = nx;
               node_prev[nd] = 9'd0;
               if (nx != 9'd0) begin
                  idx = nx - 9'd1;
                  node_prev[idx[7:0]] = self;
               end else begin
                  list_last[lst] = self;
               end
               list_first[lst] = self;
            end else begin
               pv = list_last[lst];
               node_next[nd] = 9'd0;
               node_prev[nd] = pv;
               if (pv != 9'd0) begin
                  idx = pv - 9'd1;
                  node_next[idx[7:0]] = self;
               end else begin
                  list_first[lst] = self;
               end
               list_last[lst] = self;
            end
            node_owner[nd] = {1'b0, lst} + 3'd1;
            return pack_outcome(STAT_DONE, list_first[lst], list_last[lst]);
         end
         default: begin
            if (node_owner[nd] == 3'd0) begin
               return pack_outcome(STAT_CUT_NONMEMBER, 9'd0, 9'd0);
            end
            ownm = node_owner[nd] - 3'd1;
            own  = ownm[1:0];
            nx   = node_next[nd];
            pv   = node_prev[nd];
            if (pv != 9'd0) begin
               idx = pv - 9'd1;
               node_next[idx[7:0]] = nx;
            end
            if (nx != 9'd0) begin
               idx = nx - 9'd1;
               node_prev[idx[7:0]] = pv;
            end
            if (list_first[own] == self) begin
               list_first[own] = nx;
            end
            if (list_last[own] == self) begin
               list_last[own] = pv;
            end
            node_next[nd]  = 9'd0;
            node_prev[nd]  = 9'd0;
            node_owner[nd] = 3'd0;
            return pack_outcome(STAT_DONE, list_first[own], list_last[own]);
         end
      endcase
   endfunction

   task automatic send_item(op_type op, logic [1:0] lst, logic [7:0] nd);
      req_type it;
      it.op      = op;
      it.list_id = lst;
      it.node    = nd;
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      outcome_q.push_back(list_op_outcome(it));
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (outcome_q.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = outcome_q.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_item.status, want.status));
            if (rsp_item.head_valid !== want.head_valid)
               report_mismatch($sformatf("head_valid got %0d want %0d",
                                         rsp_item.head_valid, want.head_valid));
            if (rsp_item.head_node !== want.head_node)
               report_mismatch($sformatf("head_node got %0d want %0d",
                                         rsp_item.head_node, want.head_node));
            if (rsp_item.tail_valid !== want.tail_valid)
               report_mismatch($sformatf("tail_valid got %0d want %0d",
                                         rsp_item.tail_valid, want.tail_valid));
            if (rsp_item.tail_node !== want.tail_node)
               report_mismatch($sformatf("tail_node got %0d want %0d",
                                         rsp_item.tail_node, want.tail_node));
         end
         checked_count++;
      end
   end

   task automatic test_add_and_init();
      send_item(OP_ADD_TAIL, 2'd0, 8'd0);
      send_item(OP_ADD_TAIL, 2'd0, 8'd255);
      send_item(OP_ADD_HEAD, 2'd0, 8'd1);
      send_item(OP_ADD_HEAD, 2'd3, 8'd128);
      send_item(OP_ADD_HEAD, 2'd3, 8'd127);
      send_item(OP_INIT, 2'd3, 8'd0);
   endtask

   task automatic test_member_rules();
      send_item(OP_ADD_HEAD, 2'd1, 8'd255);
      send_item(OP_ADD_TAIL, 2'd2, 8'd128);
      send_item(OP_CUT, 2'd1, 8'd200);
      send_item(OP_ADD_TAIL, 2'd3, 8'd2);
      send_item(OP_INIT, 2'd2, 8'd255);
   endtask

   task automatic test_cut_positions();
      send_item(OP_CUT, 2'd2, 8'd0);
      send_item(OP_CUT, 2'd0, 8'd1);
      send_item(OP_ADD_TAIL, 2'd0, 8'd3);
      send_item(OP_CUT, 2'd3, 8'd3);
      send_item(OP_CUT, 2'd0, 8'd255);
      send_item(OP_CUT, 2'd0, 8'd128);
      send_item(OP_CUT, 2'd1, 8'd127);
      send_item(OP_CUT, 2'd0, 8'd2);
      send_item(OP_CUT, 2'd3, 8'd0);
   endtask

   task automatic test_random_traffic(int pct, int count);
      int         pick;
      int         tries;
      logic [7:0] nd;
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if ($urandom_range(9) == 0) begin
            nd = 8'($urandom_range(255));
         end else begin
            nd = 8'($urandom_range(31));
         end
         if (pick < 4) begin
            send_item(OP_INIT, 2'($urandom_range(3)), nd);
         end else if (pick < 36) begin
            send_item(OP_ADD_HEAD, 2'($urandom_range(3)), nd);
         end else if (pick < 68) begin
            send_item(OP_ADD_TAIL, 2'($urandom_range(3)), nd);
         end else begin
            if ($urandom_range(99) < 80) begin
               tries = 0;
               while (node_owner[nd] == 3'd0 && tries < 8) begin
                  nd = 8'($urandom_range(31));
                  tries++;
               end
            end
            send_item(OP_CUT, 2'($urandom_range(3)), nd);
         end
      end
   endtask

   initial begin
      int drain;
      for (int i = 0; i < 256; i++) begin
         node_next[i]  = 9'd0;
         node_prev[i]  = 9'd0;
         node_owner[i] = 3'd0;
      end
      for (int i = 0; i < 4; i++) begin
         list_first[i] = 9'd0;
         list_last[i]  = 9'd0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_add_and_init();
      test_member_rules();
      test_cut_positions();
      test_random_traffic(31, 670);
      test_random_traffic(71, 670);
      test_random_traffic(0, 670);
      start <= 1'b0;

      drain = 0;
      while (outcome_q.size() != 0 && drain < 1000) begin
         @(posedge clock);
         drain++;
      end
      if (outcome_q.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
      end
      repeat (10) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/dllm_pkg.sv
rtl/dllm_ctrl.sv
rtl/dllm_dpath.sv
rtl/doubly_linked_list_manager.sv
dv/testbench.sv
